/* sv/bankers_request_safety_check_defines.svh */
// Assertion macros shared by the banker's request checker RTL.
`ifndef BANKERS_REQUEST_SAFETY_CHECK_DEFINES_SVH
`define BANKERS_REQUEST_SAFETY_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define BKR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bankers check: assertion failed");
`define BKR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bankers check: assertion failed");
`else
`define BKR_ASSERT(lbl, expr)
`define BKR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/bkr_pkg.sv */
// Shared types, codes and helpers for the banker's request checker.
`default_nettype none

package bkr_pkg;

    localparam int DEF_NUM_PROCS = 8;
    localparam int DEF_NUM_RES   = 4;
    localparam int MAX_RES       = 4;
    localparam int UNIT_W        = 8;
    localparam int PID_W         = 3;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [MAX_RES-1:0][UNIT_W-1:0] vec_t;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVAIL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXCEED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAFE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADLOAD = 2'd3;

    // Unsigned add that clips at the top of the unit range.
    function automatic unit_t sat_add(input unit_t a, input unit_t b);
        logic [UNIT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[UNIT_W] ? {UNIT_W{1'b1}} : s[UNIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/bkr_row_unit.sv */
// Shared row unit: checks one process row against work and forms the new work vector.
`default_nettype none

module bkr_row_unit #(
    parameter int NUM_RES = bkr_pkg::DEF_NUM_RES
) (
    input  bkr_pkg::vec_t need_row,
    input  bkr_pkg::vec_t alloc_row,
    input  bkr_pkg::vec_t work,
    output logic          fits,
    output bkr_pkg::vec_t sum
);
    import bkr_pkg::*;

    always_comb
    begin
        fits = 1'b1;
        sum  = work;
        for (int r = 0; r < NUM_RES; r++)
        begin
            if (need_row[r] > work[r])
            begin
                fits = 1'b0;
            end
            sum[r] = sat_add(work[r], alloc_row[r]);
        end
    end

endmodule

`default_nettype wire

/* sv/bankers_request_safety_check.sv */
// Top level of the banker's algorithm request checker.
//
//  Channel  Direction  Handshake             Payload
//  request  in         req_valid/req_stall   mode, proc_id, amount_0..3, held_0..3
//  result   out        rsp_valid/rsp_stall   status
//
// Load, set-available and rejected requests pass from IDLE through EXEC to FINISH.
// A request that reaches the safety check goes from EXEC through SCAN, which makes at most
// NUM_PROCS passes over the rows, to FINISH; the shared row unit visits one row a cycle.
// Reset clears the available vector and both tables at once; no clearing pass.
// One transaction is worked at a time; the next is taken while a result waits.
`default_nettype none

module bankers_request_safety_check #(
    parameter int NUM_PROCS = bkr_pkg::DEF_NUM_PROCS,
    parameter int NUM_RES   = bkr_pkg::DEF_NUM_RES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [bkr_pkg::MODE_W-1:0]    mode,
    input  logic [bkr_pkg::PID_W-1:0]     proc_id,
    input  logic [bkr_pkg::UNIT_W-1:0]    amount_0,
    input  logic [bkr_pkg::UNIT_W-1:0]    amount_1,
    input  logic [bkr_pkg::UNIT_W-1:0]    amount_2,
    input  logic [bkr_pkg::UNIT_W-1:0]    amount_3,
    input  logic [bkr_pkg::UNIT_W-1:0]    held_0,
    input  logic [bkr_pkg::UNIT_W-1:0]    held_1,
    input  logic [bkr_pkg::UNIT_W-1:0]    held_2,
    input  logic [bkr_pkg::UNIT_W-1:0]    held_3,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [bkr_pkg::STATUS_W-1:0]  status
);
    import bkr_pkg::*;

    `include "bankers_request_safety_check_defines.svh"

    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [MODE_W-1:0]   mode_reg;
    logic [PID_W-1:0]    pid_reg;
    vec_t                amt_reg, held_reg;

    vec_t                avail_reg, avail_next;
    vec_t                alloc_reg [NUM_PROCS];
    vec_t                alloc_next [NUM_PROCS];
    vec_t                need_reg [NUM_PROCS];
    vec_t                need_next [NUM_PROCS];

    vec_t                tnt_avail_reg, tnt_avail_next;
    vec_t                tnt_alloc_reg, tnt_alloc_next;
    vec_t                tnt_need_reg, tnt_need_next;
    vec_t                work_reg, work_next;
    logic [NUM_PROCS-1:0] fin_reg, fin_next;
    logic                prog_reg, prog_next;
    logic [PW-1:0]       idx_reg, idx_next;

    logic                pid_ok;
    logic [PW-1:0]       prow;
    logic                load_bad, req_bad;
    vec_t                row_need, row_alloc, row_sum;
    logic                row_fits, take;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;

    assign pid_ok = (32'(pid_reg) < NUM_PROCS);
    assign prow   = pid_reg[PW-1:0];

    // The requesting row is read from the tentative copy during the scan.
    assign row_need  = (idx_reg == prow) ? tnt_need_reg  : need_reg[idx_reg];
    assign row_alloc = (idx_reg == prow) ? tnt_alloc_reg : alloc_reg[idx_reg];
    assign take      = !fin_reg[idx_reg] && row_fits;

    bkr_row_unit #(
        .NUM_RES (NUM_RES)
    ) u_row_unit (
        .need_row  (row_need),
        .alloc_row (row_alloc),
        .work      (work_reg),
        .fits      (row_fits),
        .sum       (row_sum)
    );

    always_comb
    begin
        load_bad = 1'b0;
        req_bad  = 1'b0;
        for (int r = 0; r < NUM_RES; r++)
        begin
            if (held_reg[r] > amt_reg[r])
            begin
                load_bad = 1'b1;
            end
            if (amt_reg[r] > need_reg[prow][r] || amt_reg[r] > avail_reg[r])
            begin
                req_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        status_next     = status_reg;
        avail_next      = avail_reg;
        alloc_next      = alloc_reg;
        need_next       = need_reg;
        tnt_avail_next  = tnt_avail_reg;
        tnt_alloc_next  = tnt_alloc_reg;
        tnt_need_next   = tnt_need_reg;
        work_next       = work_reg;
        fin_next        = fin_reg;
        prog_next       = prog_reg;
        idx_next        = idx_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_FINISH;
                status_next = ST_OK;
                case (mode_reg)
                    MODE_LOAD:
                    begin
                        if (!pid_ok || load_bad)
                        begin
                            status_next = ST_BADLOAD;
                        end
                        else
                        begin
                            for (int r = 0; r < NUM_RES; r++)
                            begin
                                alloc_next[prow][r] = held_reg[r];
                                need_next[prow][r]  = amt_reg[r] - held_reg[r];
                            end
                        end
                    end
                    MODE_AVAIL:
                    begin
                        for (int r = 0; r < NUM_RES; r++)
                        begin
                            avail_next[r] = amt_reg[r];
                        end
                    end
                    MODE_REQ:
                    begin
                        if (!pid_ok || req_bad)
                        begin
                            status_next = ST_EXCEED;
                        end
                        else
                        begin
                            tnt_avail_next = avail_reg;
                            tnt_alloc_next = alloc_reg[prow];
                            tnt_need_next  = need_reg[prow];
                            for (int r = 0; r < NUM_RES; r++)
                            begin
                                tnt_avail_next[r] = avail_reg[r] - amt_reg[r];
                                tnt_alloc_next[r] = sat_add(alloc_reg[prow][r], amt_reg[r]);
                                tnt_need_next[r]  = need_reg[prow][r] - amt_reg[r];
                            end
                            work_next  = tnt_avail_next;
                            fin_next   = '0;
                            prog_next  = 1'b0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (take)
                begin
                    work_next         = row_sum;
                    fin_next[idx_reg] = 1'b1;
                    prog_next         = 1'b1;
                end
                if (idx_reg == PW'(NUM_PROCS - 1))
                begin
                    if (&fin_next)
                    begin
                        avail_next       = tnt_avail_reg;
                        alloc_next[prow] = tnt_alloc_reg;
                        need_next[prow]  = tnt_need_reg;
                        status_next      = ST_OK;
                        state_next       = S_FINISH;
                    end
                    else if (prog_next)
                    begin
                        idx_next  = '0;
                        prog_next = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_UNSAFE;
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            fin_reg       <= '0;
            prog_reg      <= 1'b0;
            idx_reg       <= '0;
            avail_reg     <= '0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                alloc_reg[p] <= '0;
                need_reg[p]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            fin_reg       <= fin_next;
            prog_reg      <= prog_next;
            idx_reg       <= idx_next;
            avail_reg     <= avail_next;
            alloc_reg     <= alloc_next;
            need_reg      <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            mode_reg <= mode;
            pid_reg  <= proc_id;
            amt_reg  <= {amount_3, amount_2, amount_1, amount_0};
            held_reg <= {held_3, held_2, held_1, held_0};
        end
        rsp_status_reg <= rsp_status_next;
        status_reg     <= status_next;
        tnt_avail_reg  <= tnt_avail_next;
        tnt_alloc_reg  <= tnt_alloc_next;
        tnt_need_reg   <= tnt_need_next;
        work_reg       <= work_next;
    end

    `BKR_ASSERT(a_idx_range, (state_reg != S_SCAN) || (32'(idx_reg) < NUM_PROCS))
    `BKR_ASSERT(a_grant_all_fin,
        !(state_reg == S_SCAN && state_next == S_FINISH && status_next == ST_OK) || (&fin_next))
    `BKR_ASSERT_NEXT(a_hold_result,
        state_reg == S_FINISH && rsp_valid_reg && rsp_stall,
        state_reg == S_FINISH && rsp_valid_reg)
    `BKR_ASSERT_NEXT(a_req_keeps_avail, state_reg == S_EXEC && mode_reg == MODE_REQ, $stable(avail_reg))

endmodule

`default_nettype wire
